// ===== src/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants of the sprite alpha compositor
// Screen geometry, field widths, register indexes and the queue entry.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 480;

  localparam int X_W         = $clog2(SCREEN_WIDTH);
  localparam int Y_W         = $clog2(SCREEN_HEIGHT);
  localparam int ADDR_W      = 18;
  localparam int FULL_ADDR_W = 23;
  localparam int COLOR_W     = 16;
  localparam int ALPHA_W     = 8;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_ADDR_W  = 3;
  localparam int FMT_W       = 2;
  localparam int RASTER_W    = 11;
  localparam int SUM_W       = 14;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_PIXEL_FORMAT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB565 = 2'd0,
    FMT_KEYED  = 2'd1,
    FMT_BLEND  = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_COPY,
    OP_BLEND
  } op_e;

  // One classified pixel waiting for the back end.
  typedef struct packed {
    op_e                op;
    logic [COLOR_W-1:0] src;
    logic [COLOR_W-1:0] dst;
    logic [ALPHA_W-1:0] alpha;
    logic [X_W-1:0]     col;
    logic [Y_W-1:0]     row;
    logic               done;
  } entry_t;

endpackage

// ===== src/sac_front.sv =====
// ----------------------------------------------------------------------------
// sac_front: configuration, raster and pixel classification
// Holds the registers and raster counters, places and clips each pixel and
// decides whether it is skipped, copied or blended.
// ----------------------------------------------------------------------------
module sac_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sac_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            accept_i,
  input  logic [sac_pkg::COLOR_W-1:0]     src_color_i,
  input  logic [sac_pkg::ALPHA_W-1:0]     src_alpha_i,
  input  logic [sac_pkg::COLOR_W-1:0]     dst_color_i,
  output sac_pkg::entry_t                 entry_o
);
  import sac_pkg::*;

  logic signed [CFG_DATA_W-1:0] dest_x_q, dest_x_d;
  logic signed [CFG_DATA_W-1:0] dest_y_q, dest_y_d;
  logic [RASTER_W-1:0]          last_col_q, last_col_d;
  logic [RASTER_W-1:0]          last_row_q, last_row_d;
  logic [FMT_W-1:0]             fmt_q, fmt_d;
  logic [RASTER_W-1:0]          col_q, col_d;
  logic [RASTER_W-1:0]          row_q, row_d;

  logic signed [CFG_DATA_W:0]   dx, dy;
  logic                         on_screen;
  logic                         col_end, row_end;

  // Size register to last raster index: zero acts as one, saturate at 2048.
  function automatic logic [RASTER_W-1:0] last_index(logic [CFG_DATA_W-1:0] size);
    logic [CFG_DATA_W-1:0] m1;
    m1 = size - CFG_DATA_W'(1);
    if (size == '0) begin
      last_index = '0;
    end else if (size > CFG_DATA_W'(2048)) begin
      last_index = '1;
    end else begin
      last_index = m1[RASTER_W-1:0];
    end
  endfunction

  assign dx = $signed({dest_x_q[CFG_DATA_W-1], dest_x_q}) + $signed({2'b00, col_q});
  assign dy = $signed({dest_y_q[CFG_DATA_W-1], dest_y_q}) + $signed({2'b00, row_q});

  assign on_screen = !dx[CFG_DATA_W] && (dx[CFG_DATA_W-1:0] < CFG_DATA_W'(SCREEN_WIDTH))
                  && !dy[CFG_DATA_W] && (dy[CFG_DATA_W-1:0] < CFG_DATA_W'(SCREEN_HEIGHT));

  assign col_end = col_q >= last_col_q;
  assign row_end = row_q >= last_row_q;

  always_comb begin
    entry_o.src   = src_color_i;
    entry_o.dst   = dst_color_i;
    entry_o.alpha = src_alpha_i;
    entry_o.col   = dx[X_W-1:0];
    entry_o.row   = dy[Y_W-1:0];
    entry_o.done  = col_end && row_end;
    entry_o.op    = OP_SKIP;
    if (on_screen) begin
      case (fmt_q)
        FMT_RGB565: entry_o.op = OP_COPY;
        FMT_KEYED: begin
          // key bit gates the write, and is cleared in the stored pixel
          entry_o.src = {1'b0, src_color_i[COLOR_W-2:0]};
          if (src_color_i[COLOR_W-1]) entry_o.op = OP_COPY;
        end
        FMT_BLEND: begin
          if (src_alpha_i == '1) begin
            entry_o.op = OP_COPY;
          end else if (src_alpha_i != '0) begin
            entry_o.op = OP_BLEND;
          end
        end
        default: entry_o.op = OP_SKIP;
      endcase
    end
  end

  always_comb begin
    dest_x_d   = dest_x_q;
    dest_y_d   = dest_y_q;
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    fmt_d      = fmt_q;
    col_d      = col_q;
    row_d      = row_q;
    if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RASTER_W'(1);
      end else begin
        col_d = col_q + RASTER_W'(1);
      end
    end
    if (cfg_we_i) begin
      // any valid register write restarts the raster
      case (cfg_addr_i)
        REG_DEST_X: begin
          dest_x_d = $signed(cfg_data_i);
          col_d = '0;
          row_d = '0;
        end
        REG_DEST_Y: begin
          dest_y_d = $signed(cfg_data_i);
          col_d = '0;
          row_d = '0;
        end
        REG_SOURCE_WIDTH: begin
          last_col_d = last_index(cfg_data_i);
          col_d = '0;
          row_d = '0;
        end
        REG_SOURCE_HEIGHT: begin
          last_row_d = last_index(cfg_data_i);
          col_d = '0;
          row_d = '0;
        end
        REG_PIXEL_FORMAT: begin
          fmt_d = cfg_data_i[FMT_W-1:0];
          col_d = '0;
          row_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q   <= '0;
      dest_y_q   <= '0;
      last_col_q <= '0;
      last_row_q <= '0;
      fmt_q      <= FMT_RGB565;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      dest_x_q   <= dest_x_d;
      dest_y_q   <= dest_y_d;
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      fmt_q      <= fmt_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

endmodule

// ===== src/sac_queue.sv =====
// ----------------------------------------------------------------------------
// sac_queue: classified pixel queue
// Small FIFO between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module sac_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sac_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sac_pkg::entry_t rdata_o
);
  import sac_pkg::*;

  entry_t            slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign rdata_o = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + (QPTR_W + 1)'(1);
      2'b01:   count_d = count_q - (QPTR_W + 1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/sac_back.sv =====
// ----------------------------------------------------------------------------
// sac_back: blend and address pipeline
// Stage 1 multiplies channels and the row offset, stage 2 divides by 255
// and holds the result transaction in the output register.
// ----------------------------------------------------------------------------
module sac_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  sac_pkg::entry_t             entry_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        write_enable_o,
  output logic [sac_pkg::ADDR_W-1:0]  write_address_o,
  output logic [sac_pkg::COLOR_W-1:0] write_data_o,
  output logic                        image_done_o
);
  import sac_pkg::*;

  logic                   s1_valid_q;
  op_e                    s1_op_q;
  logic [ADDR_W-1:0]      s1_addr_q;
  logic [COLOR_W-1:0]     s1_copy_q;
  logic [SUM_W-1:0]       s1_r_q, s1_g_q, s1_b_q;
  logic                   s1_done_q;

  logic                   out_valid_q;
  logic                   we_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [COLOR_W-1:0]     data_q;
  logic                   done_q;

  logic                   out_adv, s1_adv;
  logic [SUM_W-1:0]       a, na;
  logic [SUM_W-1:0]       r_sum, g_sum, b_sum;
  logic [FULL_ADDR_W-1:0] full_addr;
  logic [SUM_W:0]         r_quot, g_quot, b_quot;
  logic [4:0]             r_div, b_div;
  logic [5:0]             g_div;

  // (x + 1 + (x >> 8)) >> 8 equals x / 255 over the whole sum range
  function automatic logic [SUM_W:0] div255(logic [SUM_W-1:0] x);
    logic [SUM_W:0] t;
    t = {1'b0, x} + (SUM_W + 1)'(1) + (SUM_W + 1)'(x >> 8);
    div255 = t >> 8;
  endfunction

  assign out_adv = !out_valid_q || out_ready_i;
  assign s1_adv  = !s1_valid_q || out_adv;
  assign pop_o   = valid_i && s1_adv;

  assign a  = SUM_W'(entry_i.alpha);
  assign na = SUM_W'(8'd255 - entry_i.alpha);

  assign r_sum = SUM_W'(entry_i.src[15:11]) * a + SUM_W'(entry_i.dst[15:11]) * na
               + SUM_W'(127);
  assign g_sum = SUM_W'(entry_i.src[10:5]) * a + SUM_W'(entry_i.dst[10:5]) * na
               + SUM_W'(127);
  assign b_sum = SUM_W'(entry_i.src[4:0]) * a + SUM_W'(entry_i.dst[4:0]) * na
               + SUM_W'(127);

  assign full_addr = FULL_ADDR_W'(entry_i.row) * FULL_ADDR_W'(SCREEN_WIDTH)
                   + FULL_ADDR_W'(entry_i.col);

  assign r_quot = div255(s1_r_q);
  assign g_quot = div255(s1_g_q);
  assign b_quot = div255(s1_b_q);

  assign r_div = r_quot[4:0];
  assign g_div = g_quot[5:0];
  assign b_div = b_quot[4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= valid_i;
      if (out_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_op_q   <= entry_i.op;
      s1_addr_q <= full_addr[ADDR_W-1:0];
      s1_copy_q <= entry_i.src;
      s1_r_q    <= r_sum;
      s1_g_q    <= g_sum;
      s1_b_q    <= b_sum;
      s1_done_q <= entry_i.done;
    end
    if (out_adv && s1_valid_q) begin
      we_q   <= s1_op_q != OP_SKIP;
      addr_q <= (s1_op_q != OP_SKIP) ? s1_addr_q : '0;
      done_q <= s1_done_q;
      case (s1_op_q)
        OP_COPY:  data_q <= s1_copy_q;
        OP_BLEND: data_q <= {r_div, g_div, b_div};
        default:  data_q <= '0;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = we_q;
  assign write_address_o = addr_q;
  assign write_data_o    = data_q;
  assign image_done_o    = done_q;

endmodule

// ===== src/sprite_alpha_compositor.sv =====
// ----------------------------------------------------------------------------
// sprite_alpha_compositor: RGB565 sprite compositor with clipping
// Places a raster-ordered source image onto the framebuffer, clips it to
// the screen and copies, color-keys or alpha-blends each pixel.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   -------  ---------  --------------------  -------------------------------
//   in       sink       in_valid_i/in_ready_o  src_color, src_alpha, dst_color
//   out      source     out_valid_o/out_ready_i write_enable, write_address,
//                                              write_data, image_done
//   cfg      sink       cfg_we_i (no wait)     cfg_addr_i, cfg_data_i
//
// One transaction per clock, sustained, in both directions, while out_ready_i
// stays high. The result passes, in order, the queue slot, written at the
// accepting edge, the multiply stage and the divide/output register. Reset
// (rst_ni low, async) clears the raster, the registers to their defaults and
// all valid flags; the block takes input right after release. When
// out_ready_i stays low the four-entry queue fills and in_ready_o drops; the
// front keeps taking transactions while the back end is stalled until then.
// ----------------------------------------------------------------------------
module sprite_alpha_compositor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sac_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sac_pkg::COLOR_W-1:0]     src_color_i,
  input  logic [sac_pkg::ALPHA_W-1:0]     src_alpha_i,
  input  logic [sac_pkg::COLOR_W-1:0]     dst_color_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            write_enable_o,
  output logic [sac_pkg::ADDR_W-1:0]      write_address_o,
  output logic [sac_pkg::COLOR_W-1:0]     write_data_o,
  output logic                            image_done_o
);
  import sac_pkg::*;

  entry_t front_entry;   // classified pixel from the front
  entry_t queue_entry;   // head of the queue
  logic   queue_full;
  logic   queue_valid;
  logic   queue_pop;
  logic   in_accept;

  assign in_ready_o = !queue_full;
  assign in_accept  = in_valid_i && !queue_full;

  // Front: registers, raster counters, clipping and mode decision.
  sac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_accept),
    .src_color_i (src_color_i),
    .src_alpha_i (src_alpha_i),
    .dst_color_i (dst_color_i),
    .entry_o     (front_entry)
  );

  // Decoupling queue between classification and execution.
  sac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .wdata_i (front_entry),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .rdata_o (queue_entry)
  );

  // Back: channel mix, divide by 255, address, output register.
  sac_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (queue_valid),
    .entry_i         (queue_entry),
    .pop_o           (queue_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_enable_o  (write_enable_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .image_done_o    (image_done_o)
  );

endmodule

// ===== src/sac_checker.sv =====
// ----------------------------------------------------------------------------
// sac_checker: port-level assertions for the compositor
// Checks result transactions and flow control as seen on the top level.
// ----------------------------------------------------------------------------
module sac_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            write_enable_o,
  input logic [sac_pkg::ADDR_W-1:0]      write_address_o,
  input logic [sac_pkg::COLOR_W-1:0]     write_data_o,
  input logic                            image_done_o
);
  import sac_pkg::*;

  localparam longint Area = longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(write_enable_o)
      && $stable(write_address_o) && $stable(write_data_o) && $stable(image_done_o))
    else $error("result changed while stalled");

  // skipped or clipped pixels carry an all-zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> write_address_o == '0 && write_data_o == '0)
    else $error("non-zero payload on skipped pixel");

  // writes stay inside the framebuffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |->
      (Area > (longint'(1) << ADDR_W)) || (longint'(write_address_o) < Area))
    else $error("write address beyond screen");

  // input only backs up behind a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

endmodule

bind sprite_alpha_compositor sac_checker u_sac_checker (.*);
